>>> hw/rtl/jfu_pkg.sv
// ----------------------------------------------------------------------------
// jfu_pkg - shared types for the JSON field unescape core
// Channel payloads, result status codes and the queue entry that carries one
// classified input byte from the front end to the back end.
// ----------------------------------------------------------------------------
package jfu_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_END      = 2'd1,
    ST_NOKEY    = 2'd2,
    ST_BADQUOTE = 2'd3
  } status_e;

  // Input channel payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Output channel payload
  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       is_last;
  } out_item_t;

  // One classified byte: up to three data bytes, then an optional closing
  // status result (always the last result of a document).
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      ndata;
    logic            fin_en;
    status_e         fin_st;
  } entry_t;

  // Queue occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

>>> hw/rtl/jfu_stream_if.sv
// ----------------------------------------------------------------------------
// jfu_stream_if - valid/ready stream channel
// Carries one payload per transaction; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface jfu_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/jfu_front.sv
// ----------------------------------------------------------------------------
// jfu_front - key search and value parser
// Accepts one document byte per cycle while the queue has room, tracks the parse
// phase and pushes the results that byte causes into the queue as one entry.
// ----------------------------------------------------------------------------
module jfu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  jfu_stream_if.sink          in_chan_i,
  input  jfu_pkg::fifo_stat_t fifo_stat_i,
  output logic                push_o,
  output jfu_pkg::entry_t     push_entry_o
);

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_QUOTE  = 3'd1,
    PH_VALUE  = 3'd2,
    PH_BSLASH = 3'd3,
    PH_ESCAPE = 3'd4,
    PH_DROP   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam int unsigned KeyLen = 11;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChM      = 8'h4D;
  // "Message": followed by a space
  localparam logic [7:0] KeyText [KeyLen] = '{
    8'h22, 8'h4D, 8'h65, 8'h73, 8'h73, 8'h61, 8'h67, 8'h65, 8'h22, 8'h3A, 8'h20
  };

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r.ok  = 1'b1;
      r.val = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.ok  = 1'b1;
      r.val = b[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 16'h007F) begin
      r.bytes[0] = cp[7:0];
      r.n        = 2'd1;
    end else if (cp <= 16'h07FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.n        = 2'd2;
    end else begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.n        = 2'd3;
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  key_pos_q, key_pos_d;
  logic [2:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        hex_stop_q, hex_stop_d;

  logic            acc;
  logic [7:0]      b;
  hex_t            hx;
  utf8_t           enc;
  jfu_pkg::entry_t ent;

  assign in_chan_i.ready = !fifo_stat_i.full;
  assign acc             = in_chan_i.valid && in_chan_i.ready;
  assign b               = in_chan_i.data.in_byte;
  assign hx              = hex_decode(b);

  // Next state and results of the accepted byte
  always_comb begin
    phase_d    = phase_q;
    key_pos_d  = key_pos_q;
    hex_cnt_d  = hex_cnt_q;
    cp_d       = cp_q;
    hex_stop_d = hex_stop_q;
    ent        = '0;
    ent.fin_st = jfu_pkg::ST_DATA;
    enc        = utf8_encode(cp_q);

    case (phase_q)
      PH_SEARCH: begin
        if (b == KeyText[key_pos_q]) begin
          key_pos_d = key_pos_q + 4'd1;
        end else if (key_pos_q == 4'd9 && b == ChM) begin
          key_pos_d = 4'd2;
        end else if (b == ChQuote) begin
          key_pos_d = 4'd1;
        end else begin
          key_pos_d = 4'd0;
        end
        if (key_pos_d == 4'(KeyLen)) begin
          key_pos_d = 4'd0;
          phase_d   = PH_QUOTE;
        end
      end
      PH_QUOTE: begin
        if (b == ChQuote) begin
          phase_d = PH_VALUE;
        end else begin
          ent.fin_en = 1'b1;
          ent.fin_st = jfu_pkg::ST_BADQUOTE;
          phase_d    = PH_DROP;
        end
      end
      PH_VALUE: begin
        if (b == ChQuote) begin
          ent.fin_en = 1'b1;
          ent.fin_st = jfu_pkg::ST_END;
          phase_d    = PH_DROP;
        end else if (b == ChBslash) begin
          phase_d = PH_BSLASH;
        end else begin
          ent.data[0] = b;
          ent.ndata   = 2'd1;
        end
      end
      PH_BSLASH: begin
        if (b == ChU) begin
          phase_d    = PH_ESCAPE;
          hex_cnt_d  = 3'd0;
          cp_d       = 16'd0;
          hex_stop_d = 1'b0;
        end else if (b == ChBslash) begin
          ent.data[0] = ChBslash;
          ent.ndata   = 2'd1;
        end else if (b == ChQuote) begin
          // literal backslash, then the quote closes the value
          ent.data[0] = ChBslash;
          ent.ndata   = 2'd1;
          ent.fin_en  = 1'b1;
          ent.fin_st  = jfu_pkg::ST_END;
          phase_d     = PH_DROP;
        end else begin
          ent.data[0] = ChBslash;
          ent.data[1] = b;
          ent.ndata   = 2'd2;
          phase_d     = PH_VALUE;
        end
      end
      PH_ESCAPE: begin
        if (b == ChQuote) begin
          // flush digits collected so far, then close
          ent.data   = enc.bytes;
          ent.ndata  = enc.n;
          ent.fin_en = 1'b1;
          ent.fin_st = jfu_pkg::ST_END;
          phase_d    = PH_DROP;
        end else begin
          if (!hex_stop_q && hx.ok) begin
            cp_d = {cp_q[11:0], hx.val};
          end else begin
            hex_stop_d = 1'b1;
          end
          hex_cnt_d = hex_cnt_q + 3'd1;
          if (hex_cnt_d >= 3'd4) begin
            enc       = utf8_encode(cp_d);
            ent.data  = enc.bytes;
            ent.ndata = enc.n;
            phase_d   = PH_VALUE;
          end
        end
      end
      default: ;
    endcase

    // End of document: closing status unless already given, then full reset
    if (in_chan_i.data.in_last) begin
      if (phase_d != PH_DROP) begin
        ent.fin_en = 1'b1;
        ent.fin_st = (phase_d == PH_SEARCH) ? jfu_pkg::ST_NOKEY : jfu_pkg::ST_BADQUOTE;
      end
      phase_d    = PH_SEARCH;
      key_pos_d  = 4'd0;
      hex_cnt_d  = 3'd0;
      cp_d       = 16'd0;
      hex_stop_d = 1'b0;
    end
  end

  assign push_entry_o = ent;
  assign push_o       = acc && (ent.fin_en || ent.ndata != 2'd0);

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEARCH;
      key_pos_q  <= 4'd0;
      hex_cnt_q  <= 3'd0;
      cp_q       <= 16'd0;
      hex_stop_q <= 1'b0;
    end else if (acc) begin
      phase_q    <= phase_d;
      key_pos_q  <= key_pos_d;
      hex_cnt_q  <= hex_cnt_d;
      cp_q       <= cp_d;
      hex_stop_q <= hex_stop_d;
    end
  end

  // A final byte always leaves the parser back in key search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_chan_i.data.in_last |=> phase_q == PH_SEARCH && key_pos_q == 4'd0)
    else $error("parser not returned to key search after final byte");

  // The key position never runs past the key text during search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SEARCH |-> key_pos_q < 4'(KeyLen))
    else $error("key position out of range");

  // Nothing is emitted while waiting for the end of the document
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && phase_q == PH_DROP && !in_chan_i.data.in_last |-> !push_o)
    else $error("result emitted after the value ended");

endmodule

>>> hw/rtl/jfu_queue.sv
// ----------------------------------------------------------------------------
// jfu_queue - entry queue between parser and result serialiser
// Register-based FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module jfu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jfu_pkg::entry_t     push_entry_i,
  input  logic                pop_i,
  output jfu_pkg::entry_t     head_o,
  output jfu_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jfu_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign head_o       = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !stat_o.full)
    else $error("push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");

endmodule

>>> hw/rtl/jfu_back.sv
// ----------------------------------------------------------------------------
// jfu_back - result serialiser
// Walks the head entry one result per cycle into the output register while the
// output is not stalled, and pops the entry with its last result.
// ----------------------------------------------------------------------------
module jfu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jfu_pkg::entry_t     head_i,
  input  jfu_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  jfu_stream_if.source        out_chan_o
);

  logic [1:0]       idx_q, idx_d;
  logic             ovalid_q;
  jfu_pkg::out_item_t oitem_q, piece;
  logic             load, piece_final;
  logic [2:0]       total;

  assign total = {1'b0, head_i.ndata} + {2'b00, head_i.fin_en};
  assign load  = !fifo_stat_i.empty && (!ovalid_q || out_chan_o.ready);

  // Select the current result of the head entry
  always_comb begin
    if (idx_q < head_i.ndata) begin
      piece.out_byte = head_i.data[idx_q];
      piece.status   = jfu_pkg::ST_DATA;
      piece.is_last  = 1'b0;
    end else begin
      piece.out_byte = 8'd0;
      piece.status   = head_i.fin_st;
      piece.is_last  = 1'b1;
    end
    piece_final = ({1'b0, idx_q} + 3'd1 == total);
    idx_d       = piece_final ? 2'd0 : idx_q + 2'd1;
  end

  assign pop_o            = load && piece_final;
  assign out_chan_o.valid = ovalid_q;
  assign out_chan_o.data  = oitem_q;

  // Control: position in entry and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else if (load) begin
      idx_q    <= idx_d;
      ovalid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      oitem_q <= piece;
    end
  end

  // Queued entries always carry at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_stat_i.empty |-> total != 3'd0)
    else $error("empty entry in queue");

  // Data results never close a document; status results always do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> ((oitem_q.status == jfu_pkg::ST_DATA) == !oitem_q.is_last))
    else $error("status and last flag disagree");

endmodule

>>> hw/rtl/json_field_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_field_unescape_utf8_core - JSON "Message" field extractor
// Finds the "Message" key in a byte stream, decodes the quoted value with
// \u escapes turned into UTF-8 and reports how the value ended.
//
//   Channel     Dir  Payload                         Transaction
//   in_chan_i   in   in_byte[8], in_last             one document byte
//   out_chan_o  out  out_byte[8], status[2], is_last one result
//
// Input takes one byte per cycle while the queue has room.
// Each byte causes zero to four results; the output gives one result per
// cycle while the receiver is ready, so a byte's results hold the serialiser
// until all are out and the QueueDepth-entry queue absorbs the difference.
// A result passes through the queue entry and then the output register.
// Output stalls back-pressure the input only once the queue is full.
// Asynchronous active-low reset; no memory clearing pass.
// ----------------------------------------------------------------------------
module json_field_unescape_utf8_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jfu_stream_if.sink   in_chan_i,
  jfu_stream_if.source out_chan_o
);

  jfu_pkg::entry_t     push_entry, head;
  jfu_pkg::fifo_stat_t fifo_stat;
  logic                push, pop;

  // Parser front end
  jfu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_chan_i    (in_chan_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decoupling queue
  jfu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (fifo_stat)
  );

  // Result serialiser
  jfu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_chan_o  (out_chan_o)
  );

endmodule

>>> tb/json_field_unescape_utf8_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_field_unescape_utf8_core_tb - self-checking bench for the field core
// Streams JSON documents byte by byte into the core and compares every result
// against a cycle-free model of the key search, value pass-through and \u to
// UTF-8 decoding. Both channels idle at random; the receiver holds off once
// for a long stretch so the internal queue fills and stalls the input.
// ----------------------------------------------------------------------------

package json_unescape_check_pkg;

  // Characters the decoder reacts to
  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_BSLASH  = 8'h5C;
  localparam logic [7:0]  CH_LOWER_U = 8'h75;
  localparam logic [7:0]  CH_UPPER_M = 8'h4D;
  localparam int unsigned KEY_LEN    = 11;
  // Key position just past the closing quote of the key name
  localparam int unsigned KEY_M_POS  = 9;
  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "\"Message\": ";

  typedef enum logic [2:0] {
    SCAN_KEY,
    WAIT_OPEN_QUOTE,
    IN_VALUE,
    AFTER_BSLASH,
    IN_ESCAPE,
    SKIP_REST
  } scan_e;

  function automatic logic [7:0] key_char(int unsigned k);
    return KEY_TEXT[8*(KEY_LEN-1-k) +: 8];
  endfunction

  // 1 when c is a hex digit; v gets its value
  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Tracks the decoder state and holds the results still to come
  class utf8_unescape_scoreboard;
    scan_e              scan;
    logic [3:0]         key_pos;
    logic [2:0]         hex_cnt;
    logic [15:0]        code_pt;
    logic               hex_stop;
    jfu_pkg::out_item_t pending_results[$];
    int unsigned        bytes_seen;
    int unsigned        docs_seen;
    int unsigned        results_seen;
    int unsigned        n_errors;
    int unsigned        status_count[4];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      scan     = SCAN_KEY;
      key_pos  = '0;
      hex_cnt  = '0;
      code_pt  = '0;
      hex_stop = 1'b0;
    endfunction

    function void queue_result(logic [7:0] b, jfu_pkg::status_e st, logic fin);
      jfu_pkg::out_item_t r;
      r.out_byte = b;
      r.status   = st;
      r.is_last  = fin;
      pending_results.push_back(r);
    endfunction

    // Code point to one, two or three UTF-8 bytes
    function void queue_utf8(logic [15:0] cp);
      if (cp <= 16'h007F) begin
        queue_result(cp[7:0], jfu_pkg::ST_DATA, 1'b0);
      end else if (cp <= 16'h07FF) begin
        queue_result({3'b110, cp[10:6]}, jfu_pkg::ST_DATA, 1'b0);
        queue_result({2'b10, cp[5:0]}, jfu_pkg::ST_DATA, 1'b0);
      end else begin
        queue_result({4'b1110, cp[15:12]}, jfu_pkg::ST_DATA, 1'b0);
        queue_result({2'b10, cp[11:6]}, jfu_pkg::ST_DATA, 1'b0);
        queue_result({2'b10, cp[5:0]}, jfu_pkg::ST_DATA, 1'b0);
      end
    endfunction

    // One accepted document byte
    function void absorb_byte(jfu_pkg::in_item_t it);
      logic [7:0] b;
      logic [3:0] nib;
      bit         digit_ok;
      b = it.in_byte;
      bytes_seen++;
      case (scan)
        SCAN_KEY: begin
          if (key_pos < KEY_LEN && b == key_char(key_pos)) key_pos = key_pos + 4'd1;
          else if (key_pos == KEY_M_POS && b == CH_UPPER_M) key_pos = 4'd2;
          else if (b == CH_QUOTE) key_pos = 4'd1;
          else key_pos = 4'd0;
          if (key_pos >= KEY_LEN) begin
            key_pos = 4'd0;
            scan    = WAIT_OPEN_QUOTE;
          end
        end
        WAIT_OPEN_QUOTE: begin
          if (b == CH_QUOTE) begin
            scan = IN_VALUE;
          end else begin
            queue_result(8'h00, jfu_pkg::ST_BADQUOTE, 1'b1);
            scan = SKIP_REST;
          end
        end
        IN_VALUE: begin
          if (b == CH_QUOTE) begin
            queue_result(8'h00, jfu_pkg::ST_END, 1'b1);
            scan = SKIP_REST;
          end else if (b == CH_BSLASH) begin
            scan = AFTER_BSLASH;
          end else begin
            queue_result(b, jfu_pkg::ST_DATA, 1'b0);
          end
        end
        AFTER_BSLASH: begin
          if (b == CH_LOWER_U) begin
            scan     = IN_ESCAPE;
            hex_cnt  = '0;
            code_pt  = '0;
            hex_stop = 1'b0;
          end else if (b == CH_BSLASH) begin
            // literal backslash; the second one may still open an escape
            queue_result(CH_BSLASH, jfu_pkg::ST_DATA, 1'b0);
          end else begin
            queue_result(CH_BSLASH, jfu_pkg::ST_DATA, 1'b0);
            if (b == CH_QUOTE) begin
              queue_result(8'h00, jfu_pkg::ST_END, 1'b1);
              scan = SKIP_REST;
            end else begin
              queue_result(b, jfu_pkg::ST_DATA, 1'b0);
              scan = IN_VALUE;
            end
          end
        end
        IN_ESCAPE: begin
          if (b == CH_QUOTE) begin
            queue_utf8(code_pt);
            queue_result(8'h00, jfu_pkg::ST_END, 1'b1);
            scan = SKIP_REST;
          end else begin
            digit_ok = hex_nibble(b, nib);
            if (!hex_stop && digit_ok) code_pt = {code_pt[11:0], nib};
            else hex_stop = 1'b1;
            hex_cnt = hex_cnt + 3'd1;
            if (hex_cnt >= 3'd4) begin
              queue_utf8(code_pt);
              scan = IN_VALUE;
            end
          end
        end
        default: ;
      endcase

      // Final byte closes the document whatever the state
      if (it.in_last) begin
        if (scan != SKIP_REST)
          queue_result(8'h00, (scan == SCAN_KEY) ? jfu_pkg::ST_NOKEY : jfu_pkg::ST_BADQUOTE,
                       1'b1);
        clear_state();
        docs_seen++;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      n_errors++;
    endtask

    task check_result(jfu_pkg::out_item_t got);
      jfu_pkg::out_item_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d not expected: byte=%02h status=%0d last=%0b",
                                  results_seen, got.out_byte, got.status, got.is_last));
        return;
      end
      want = pending_results.pop_front();
      status_count[want.status]++;
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                  results_seen, got.out_byte, want.out_byte));
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_seen, got.status, want.status));
      if (got.is_last !== want.is_last)
        report_mismatch($sformatf("result %0d is_last %0b, expected %0b",
                                  results_seen, got.is_last, want.is_last));
    endtask

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

module json_field_unescape_utf8_core_tb;

  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned LONG_HOLD    = 64;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;

  localparam logic [7:0] CH_QUOTE   = json_unescape_check_pkg::CH_QUOTE;
  localparam logic [7:0] CH_BSLASH  = json_unescape_check_pkg::CH_BSLASH;
  localparam logic [7:0] CH_LOWER_U = json_unescape_check_pkg::CH_LOWER_U;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jfu_stream_if #(.payload_t(jfu_pkg::in_item_t))  in_if ();
  jfu_stream_if #(.payload_t(jfu_pkg::out_item_t)) out_if ();

  json_field_unescape_utf8_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if)
  );

  json_unescape_check_pkg::utf8_unescape_scoreboard sb = new();

  jfu_pkg::in_item_t stim_q[$];
  int unsigned       quiet_from;
  bit                quiet_tail = 1'b0;
  bit                feed_done  = 1'b0;
  bit                held_off   = 1'b0;
  int unsigned       idle_cycles = 0;

  // Clock and reset
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void put_byte(logic [7:0] b, logic fin);
    jfu_pkg::in_item_t it;
    it.in_byte = b;
    it.in_last = fin;
    stim_q.push_back(it);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endfunction

  function automatic void mark_last();
    jfu_pkg::in_item_t it;
    it = stim_q.pop_back();
    it.in_last = 1'b1;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_byte_except(int lo, int hi, logic [7:0] a,
                                                  logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(lo, hi)); while (v == a || v == b);
    return v;
  endfunction

  function automatic logic [7:0] hex_text(logic [3:0] v);
    if (v < 4'd10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) != 0) return 8'(8'h41 + v - 4'd10);
    return 8'(8'h61 + v - 4'd10);
  endfunction

  // Any byte that stops digit collection without ending the value
  function automatic logic [7:0] rand_non_hex();
    logic [7:0] v;
    logic [3:0] dummy;
    do v = 8'($urandom_range(0, 255));
    while (json_unescape_check_pkg::hex_nibble(v, dummy) || v == CH_QUOTE);
    return v;
  endfunction

  function automatic void put_escape();
    logic [15:0] cp;
    int          ndig;
    put_text("\\u");
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 3))
        0: cp = 16'($urandom_range(0, 'h7F));
        1: cp = 16'($urandom_range('h80, 'h7FF));
        2: cp = 16'($urandom_range('h800, 'hFFFF));
        default: begin
          case ($urandom_range(0, 5))
            0: cp = 16'h0000;
            1: cp = 16'h007F;
            2: cp = 16'h0080;
            3: cp = 16'h07FF;
            4: cp = 16'h0800;
            default: cp = 16'hFFFF;
          endcase
        end
      endcase
      for (int k = 3; k >= 0; k--) put_byte(hex_text(cp[4*k +: 4]), 1'b0);
    end else begin
      // short escape: the stop byte and whatever follows fill the four slots
      ndig = $urandom_range(0, 3);
      for (int k = 0; k < ndig; k++) put_byte(hex_text(4'($urandom_range(0, 15))), 1'b0);
      put_byte(rand_non_hex(), 1'b0);
      for (int k = ndig + 1; k < 4; k++)
        put_byte(rand_byte_except(0, 255, CH_QUOTE, CH_QUOTE), 1'b0);
    end
  endfunction

  function automatic void put_value_token();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_byte(rand_byte_except(0, 255, CH_QUOTE, CH_BSLASH), 1'b0);
      4, 5: put_escape();
      6: begin
        put_byte(CH_BSLASH, 1'b0);
        put_byte(rand_byte_except(0, 255, CH_QUOTE, CH_LOWER_U), 1'b0);
      end
      7: put_text("\\\\");
      default: put_byte(rand_byte_except('h20, 'h7E, CH_QUOTE, CH_BSLASH), 1'b0);
    endcase
  endfunction

  // Noise and near-misses of the key ahead of the real one
  function automatic void put_prefix();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: put_text("\"Mess");
        1: put_text("\"Message\"");
        2: put_byte(CH_QUOTE, 1'b0);
        default: put_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
  endfunction

  function automatic void put_key();
    if ($urandom_range(0, 3) == 0) put_text("\"Message\"Message\": ");
    else put_text("\"Message\": ");
  endfunction

  function automatic void put_trailer();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void put_random_doc();
    int kind;
    int ntok;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      // well-formed value with random content
      put_prefix();
      put_key();
      put_byte(CH_QUOTE, 1'b0);
      ntok = $urandom_range(0, 6);
      repeat (ntok) put_value_token();
      case ($urandom_range(0, 5))
        0: put_text("\\\"");
        1: begin
          put_text("\\u");
          repeat ($urandom_range(0, 3)) put_byte(hex_text(4'($urandom_range(0, 15))), 1'b0);
          put_byte(CH_QUOTE, 1'b0);
        end
        default: put_byte(CH_QUOTE, 1'b0);
      endcase
      put_trailer();
    end else if (kind < 14) begin
      // no opening quote after the key
      put_prefix();
      put_key();
      put_byte(rand_byte_except(0, 255, CH_QUOTE, CH_QUOTE), 1'b0);
      put_trailer();
    end else if (kind == 14) begin
      // key completes on the final byte
      put_prefix();
      put_key();
    end else if (kind < 17) begin
      // document cut off inside the value
      put_prefix();
      put_key();
      put_byte(CH_QUOTE, 1'b0);
      ntok = $urandom_range(0, 4);
      repeat (ntok) put_value_token();
    end else begin
      ntok = $urandom_range(1, 8);
      for (int i = 0; i < ntok; i++) begin
        if ($urandom_range(0, 5) == 0) put_text("\"Message\"");
        else put_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    mark_last();
  endfunction

  function automatic void build_stimulus();
    int unsigned directed_n;
    // Code point extremes and raw extreme bytes in one value
    put_text("\"Message\": \"\\u0000\\uFFFF\\u07ff\\u0800\\u0080\\u007F");
    put_byte(8'hFF, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(CH_QUOTE, 1'b0);
    put_byte("}", 1'b1);
    // M after the key quote, plain and doubled backslash, digit stops,
    // quote inside an escape, then a dropped byte
    put_text("\"Message\"Message\": \"\\q\\\\u0041\\uZ9AB\\u4G12\\u4\"");
    put_byte(" ", 1'b1);
    // Missing quote, key ending the document, key never found
    put_text("\"Message\": ");
    put_byte("x", 1'b1);
    put_text("\"Message\": ");
    mark_last();
    put_text("\"Mess");
    put_byte(8'h00, 1'b1);
    // Document ending inside the value, on a backslash
    put_text("\"Message\": \"ab\\");
    mark_last();
    directed_n = stim_q.size();
    while (stim_q.size() < directed_n + RANDOM_ITEMS) put_random_doc();
    quiet_from = stim_q.size() * 4 / 5;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Input side: random gaps until the tail of the run
  initial begin : feed
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    build_stimulus();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int idx = 0; idx < stim_q.size(); idx++) begin
      if (idx >= quiet_from) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.data  <= stim_q[idx];
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
    end
    in_if.valid <= 1'b0;
    feed_done = 1'b1;
  end

  // Output side: one long hold-off to fill the queue, plus random stalls until the tail
  initial begin : drain
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!held_off && sb.results_seen >= 20) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  // Transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.absorb_byte(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, sb.outstanding());
        $display("json_field_unescape_utf8_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : run
    wait (feed_done);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.outstanding() != 0) sb.report_mismatch("results still outstanding at end of run");
    $display("Streamed %0d documents (%0d bytes); checked %0d results.",
             sb.docs_seen, sb.bytes_seen, sb.results_seen);
    $display("Results by kind: %0d data, %0d value end, %0d key absent, %0d quote error.",
             sb.status_count[jfu_pkg::ST_DATA], sb.status_count[jfu_pkg::ST_END],
             sb.status_count[jfu_pkg::ST_NOKEY], sb.status_count[jfu_pkg::ST_BADQUOTE]);
    if (sb.n_errors == 0) begin
      $display("json_field_unescape_utf8_core_tb: PASS");
    end else begin
      $display("json_field_unescape_utf8_core_tb: FAIL");
    end
    $finish;
  end

endmodule
